### hdl/rpss_pkg.sv
// ----------------------------------------------------------------------------
// rpss_pkg
// Shared constants and types for the record/play step sequencer.
// ----------------------------------------------------------------------------
package rpss_pkg;

	localparam int MAX_STEPS = 100;
	localparam int IDX_W     = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
	localparam int CNT_W     = $clog2(MAX_STEPS + 1);

	localparam int PITCH_W   = 6;
	localparam int SLOT_W    = 8;
	localparam int REST_BIT  = 6;
	localparam int TIE_BIT   = 7;

	localparam int OUT_IDX_W  = 7;
	localparam int OUT_CNT_W  = 7;
	localparam int OUT_LAST_W = 8;
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 40;

	typedef enum logic [2:0] {
		FUNC_EDGE   = 3'd0,
		FUNC_NOTE   = 3'd1,
		FUNC_REST   = 3'd2,
		FUNC_TIE    = 3'd3,
		FUNC_RECORD = 3'd4,
		FUNC_PLAY   = 3'd5,
		FUNC_CLEAR  = 3'd6,
		FUNC_REWIND = 3'd7
	} func_t;

endpackage

### hdl/record_play_step_sequencer.sv
// ----------------------------------------------------------------------------
// record_play_step_sequencer
// Step store of recorded notes, rests and ties, played back one slot per edge.
// ----------------------------------------------------------------------------
// One command enters per transaction on the s_ channel: the command code in
// s_tuser, pitch and enable in s_tdata. Every command gives exactly one
// result transaction on the m_ channel carrying the played step (if any)
// and the sequencer status after the command.
// Record, mode, clear and rewind commands write their result to the output
// register on the cycle after acceptance. An edge that plays a slot reads
// the slot RAM into its read register, then the read state registers the
// result; s_tready stays low in the read state, so no command overlaps it.
// The output register decouples the sides: a new command is accepted while
// a result is being taken. While m_tready is low with a result pending, no
// further command is accepted and s_tready stays low.
// Reset empties the store, clears record and play modes, rewinds playback
// and clears the output register. Slot contents need no clearing, since
// only slots below the fill count are ever read.
// ----------------------------------------------------------------------------
module record_play_step_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // pitch[5:0], enable[6], zero[7]
	input  logic [2:0]  s_tuser,  // func[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // step_played, slot_index[6:0], step_pitch[5:0],
	                              // gate_on, tie_on, retrigger, recording,
	                              // playing, filled_count[6:0],
	                              // last_played[7:0], zero[5:0]
);

	localparam int IDX_W = rpss_pkg::IDX_W;
	localparam int CNT_W = rpss_pkg::CNT_W;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;

	state_t                        state_q;
	logic [CNT_W-1:0]              fill_q, fill_d;
	logic [IDX_W-1:0]              pos_q, pos_d;
	logic                          last_vld_q, last_vld_d;
	logic [IDX_W-1:0]              last_idx_q, last_idx_d;
	logic                          record_q, record_d;
	logic                          play_q, play_d;
	logic                          m_tvalid_q;
	logic [rpss_pkg::OUT_DATA_W-1:0] m_tdata_q;

	rpss_pkg::func_t               func;
	logic [rpss_pkg::PITCH_W-1:0]  pitch;
	logic                          enable;
	logic                          accept;
	logic                          full;
	logic [IDX_W-1:0]              eff_pos;
	logic [CNT_W-1:0]              pos_inc;
	logic                          we;
	logic                          re;
	logic [rpss_pkg::SLOT_W-1:0]   wdata;
	logic [rpss_pkg::SLOT_W-1:0]   rdata;
	logic                          go_read;
	logic [rpss_pkg::OUT_DATA_W-1:0] res_now;
	logic [rpss_pkg::OUT_DATA_W-1:0] res_read;
	logic [rpss_pkg::OUT_LAST_W-1:0] last_now;
	logic [rpss_pkg::OUT_LAST_W-1:0] last_reg;
	logic                          rd_rest;
	logic                          rd_tie;

	assign func   = rpss_pkg::func_t'(s_tuser);
	assign pitch  = s_tdata[rpss_pkg::PITCH_W-1:0];
	assign enable = s_tdata[rpss_pkg::PITCH_W];

	assign s_tready = (state_q == ST_IDLE) && (!m_tvalid_q || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign full    = (fill_q >= CNT_W'(rpss_pkg::MAX_STEPS));
	assign eff_pos = (CNT_W'(pos_q) >= fill_q) ? '0 : pos_q;
	assign pos_inc = CNT_W'(eff_pos) + CNT_W'(1);

	always_comb begin
		fill_d     = fill_q;
		pos_d      = pos_q;
		last_vld_d = last_vld_q;
		last_idx_d = last_idx_q;
		record_d   = record_q;
		play_d     = play_q;
		we         = 1'b0;
		re         = 1'b0;
		wdata      = '0;
		go_read    = 1'b0;
		unique case (func)
			rpss_pkg::FUNC_EDGE: begin
				if (fill_q != '0) begin
					re         = 1'b1;
					go_read    = 1'b1;
					last_vld_d = 1'b1;
					last_idx_d = eff_pos;
					pos_d      = (pos_inc >= fill_q) ? '0 : IDX_W'(pos_inc);
				end
			end
			rpss_pkg::FUNC_NOTE, rpss_pkg::FUNC_REST, rpss_pkg::FUNC_TIE: begin
				unique case (func)
					rpss_pkg::FUNC_NOTE: wdata = {2'b00, pitch};
					rpss_pkg::FUNC_REST: wdata = {2'b01, {rpss_pkg::PITCH_W{1'b0}}};
					default:             wdata = {2'b10, pitch};
				endcase
				if (record_q && !full) begin
					we     = 1'b1;
					fill_d = fill_q + CNT_W'(1);
					if (fill_d == CNT_W'(rpss_pkg::MAX_STEPS)) begin
						record_d = 1'b0;
					end
				end
			end
			rpss_pkg::FUNC_RECORD: begin
				record_d = enable && !full;
			end
			rpss_pkg::FUNC_PLAY: begin
				play_d = enable;
			end
			rpss_pkg::FUNC_CLEAR: begin
				fill_d     = '0;
				pos_d      = '0;
				last_vld_d = 1'b0;
			end
			default: begin
				pos_d      = '0;
				last_vld_d = 1'b0;
			end
		endcase
	end

	rpss_ram #(
		.WIDTH(rpss_pkg::SLOT_W),
		.DEPTH(rpss_pkg::MAX_STEPS)
	) u_slot_ram (
		.clk  (clk),
		.we   (accept && we),
		.waddr(IDX_W'(fill_q)),
		.wdata(wdata),
		.re   (accept && re),
		.raddr(eff_pos),
		.rdata(rdata)
	);

	assign last_now = last_vld_d ? rpss_pkg::OUT_LAST_W'(last_idx_d) : '1;
	assign last_reg = last_vld_q ? rpss_pkg::OUT_LAST_W'(last_idx_q) : '1;

	assign res_now = {6'b0, last_now, rpss_pkg::OUT_CNT_W'(fill_d), play_d, record_d,
		3'b000, {rpss_pkg::PITCH_W{1'b0}}, {rpss_pkg::OUT_IDX_W{1'b0}}, 1'b0};

	assign rd_rest = rdata[rpss_pkg::REST_BIT];
	assign rd_tie  = rdata[rpss_pkg::TIE_BIT];

	assign res_read = {6'b0, last_reg, rpss_pkg::OUT_CNT_W'(fill_q), play_q, record_q,
		!rd_rest && !rd_tie, !rd_rest && rd_tie, !rd_rest,
		rdata[rpss_pkg::PITCH_W-1:0], rpss_pkg::OUT_IDX_W'(last_idx_q), 1'b1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fill_q     <= '0;
			pos_q      <= '0;
			last_vld_q <= 1'b0;
			last_idx_q <= '0;
			record_q   <= 1'b0;
			play_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						fill_q     <= fill_d;
						pos_q      <= pos_d;
						last_vld_q <= last_vld_d;
						last_idx_q <= last_idx_d;
						record_q   <= record_d;
						play_q     <= play_d;
						if (go_read) begin
							state_q <= ST_READ;
						end else begin
							m_tdata_q <= res_now;
						end
					end
				end
				default: begin
					m_tdata_q <= res_read;
					state_q   <= ST_IDLE;
				end
			endcase
			if ((state_q == ST_READ) || (accept && !go_read)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(rpss_pkg::MAX_STEPS))
		else $error("fill count beyond store depth");

	a_record_room: assert property (@(posedge clk) disable iff (!arst_n)
		record_q |-> (fill_q < CNT_W'(rpss_pkg::MAX_STEPS)))
		else $error("record mode on a full store");

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(CNT_W'(pos_q) < fill_q) || (pos_q == '0))
		else $error("play position outside filled slots");

	a_read_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> !m_tvalid_q)
		else $error("slot read completes with output register occupied");

	a_read_follows_edge: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> $past(accept) && ($past(func) == rpss_pkg::FUNC_EDGE))
		else $error("slot read without an accepted edge");

endmodule

### hdl/rpss_ram.sv
// ----------------------------------------------------------------------------
// rpss_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module rpss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the record/play step sequencer.
// ----------------------------------------------------------------------------
// Commands go in on the s_ stream with random gaps, and results are taken on
// the m_ stream with random stalls. A behavioral model of the slot store
// predicts one result per accepted command. The checker compares each result
// transaction, field by field, with the oldest prediction. Directed tests
// cover the empty store, every command and the full store. Random recording
// and playback sequences with some noise make up the rest of the run.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEM_TARGET = 1250;
	localparam int CYCLE_LIMIT = 500000;
	localparam logic [7:0] REST_SLOT = 8'h1 << rpss_pkg::REST_BIT;
	localparam logic [7:0] TIE_FLAG  = 8'h1 << rpss_pkg::TIE_BIT;

	// Laid out in the same bit order as m_tdata.
	typedef struct packed {
		logic [5:0] pad;
		logic [7:0] last;
		logic [6:0] filled;
		logic       playing;
		logic       recording;
		logic       retrig;
		logic       tie;
		logic       gate;
		logic [5:0] pitch;
		logic [6:0] slot;
		logic       played;
	} step_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;

	logic [7:0]   pattern_slots [rpss_pkg::MAX_STEPS];
	int           pattern_len;
	int           play_pos;
	int           last_slot;
	bit           rec_on;
	bit           play_on;
	step_result_t pending_steps [$];

	bit steady;
	int errors;
	int cycles;
	int results_seen;
	int items_sent;
	int effective_items;
	int notes_played;
	int rests_played;
	int ties_played;
	int store_full_hits;
	int wraps_seen;
	step_result_t got_step;
	step_result_t want_step;

	record_play_step_sequencer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles,
				pending_steps.size());
			$display("status: fail");
			$finish;
		end
	end

	function automatic void append_slot(logic [7:0] bits);
		if (!rec_on || pattern_len >= rpss_pkg::MAX_STEPS)
			return;
		pattern_slots[pattern_len] = bits;
		pattern_len++;
		if (pattern_len >= rpss_pkg::MAX_STEPS)
			rec_on = 1'b0;
	endfunction

	function automatic step_result_t next_step_result(rpss_pkg::func_t f, logic [5:0] p,
		logic en);
		step_result_t r;
		logic [7:0]   bits;
		int           idx;
		r = '0;
		case (f)
			rpss_pkg::FUNC_EDGE: begin
				if (pattern_len != 0) begin
					idx = (play_pos >= pattern_len) ? 0 : play_pos;
					bits = pattern_slots[idx];
					r.played = 1'b1;
					r.slot = 7'(idx);
					r.pitch = bits[rpss_pkg::PITCH_W-1:0];
					last_slot = idx;
					if (bits[rpss_pkg::REST_BIT]) begin
						r.gate = 1'b0;
					end else if (bits[rpss_pkg::TIE_BIT]) begin
						r.gate = 1'b1;
						r.tie = 1'b1;
					end else begin
						r.gate = 1'b1;
						r.retrig = 1'b1;
					end
					play_pos = (idx + 1 >= pattern_len) ? 0 : idx + 1;
				end
			end
			rpss_pkg::FUNC_NOTE:   append_slot({2'b00, p});
			rpss_pkg::FUNC_REST:   append_slot(REST_SLOT);
			rpss_pkg::FUNC_TIE:    append_slot(TIE_FLAG | {2'b00, p});
			rpss_pkg::FUNC_RECORD: rec_on = en && (pattern_len < rpss_pkg::MAX_STEPS);
			rpss_pkg::FUNC_PLAY:   play_on = en;
			rpss_pkg::FUNC_CLEAR: begin
				pattern_len = 0;
				play_pos = 0;
				last_slot = -1;
			end
			rpss_pkg::FUNC_REWIND: begin
				play_pos = 0;
				last_slot = -1;
			end
		endcase
		r.recording = rec_on;
		r.playing = play_on;
		r.filled = 7'(pattern_len);
		r.last = 8'(last_slot);
		return r;
	endfunction

	task automatic send_cmd(rpss_pkg::func_t f, logic [5:0] p, logic en);
		int           gap;
		int           old_len;
		int           old_pos;
		int           old_last;
		bit           old_rec;
		bit           old_play;
		step_result_t r;
		gap = steady ? 0 : int'($urandom_range(0, 14));
		if (gap > 0) begin
			@(negedge clk) s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= f;
		s_tdata <= {1'b0, en, p};
		do @(posedge clk); while (!s_tready);
		items_sent++;
		old_len = pattern_len;
		old_pos = play_pos;
		old_last = last_slot;
		old_rec = rec_on;
		old_play = play_on;
		r = next_step_result(f, p, en);
		pending_steps.push_back(r);
		if (r.played || old_len != pattern_len || old_pos != play_pos ||
			old_last != last_slot || old_rec != rec_on || old_play != play_on)
			effective_items++;
		if (r.played && r.tie)
			ties_played++;
		else if (r.played && r.gate)
			notes_played++;
		else if (r.played)
			rests_played++;
		if (r.played && play_pos == 0)
			wraps_seen++;
		if (pattern_len == rpss_pkg::MAX_STEPS && old_len == rpss_pkg::MAX_STEPS - 1)
			store_full_hits++;
	endtask

	task automatic send_random_record();
		rpss_pkg::func_t f;
		f = rpss_pkg::func_t'($urandom_range(rpss_pkg::FUNC_NOTE, rpss_pkg::FUNC_TIE));
		send_cmd(f, 6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
	endtask

	task automatic drain_results();
		@(negedge clk) s_tvalid <= 1'b0;
		while (pending_steps.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Result side: a random stall before each result is taken.
	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = steady ? 0 : int'($urandom_range(0, 14));
			if (stall > 0) begin
				@(negedge clk) m_tready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk) m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch in result %0d: %s got %0d expected %0d", results_seen, what,
			got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			got_step = m_tdata;
			if (pending_steps.size() == 0) begin
				$display("result %0d arrived with no command outstanding", results_seen);
				errors++;
			end else begin
				want_step = pending_steps.pop_front();
				if (got_step.played !== want_step.played)
					report_mismatch("step_played", got_step.played, want_step.played);
				if (got_step.slot !== want_step.slot)
					report_mismatch("slot_index", got_step.slot, want_step.slot);
				if (got_step.pitch !== want_step.pitch)
					report_mismatch("step_pitch", got_step.pitch, want_step.pitch);
				if (got_step.gate !== want_step.gate)
					report_mismatch("gate_on", got_step.gate, want_step.gate);
				if (got_step.tie !== want_step.tie)
					report_mismatch("tie_on", got_step.tie, want_step.tie);
				if (got_step.retrig !== want_step.retrig)
					report_mismatch("retrigger", got_step.retrig, want_step.retrig);
				if (got_step.recording !== want_step.recording)
					report_mismatch("recording", got_step.recording, want_step.recording);
				if (got_step.playing !== want_step.playing)
					report_mismatch("playing", got_step.playing, want_step.playing);
				if (got_step.filled !== want_step.filled)
					report_mismatch("filled_count", got_step.filled, want_step.filled);
				if (got_step.last !== want_step.last)
					report_mismatch("last_played", $signed(got_step.last),
						$signed(want_step.last));
				if (got_step.pad !== want_step.pad)
					report_mismatch("padding", got_step.pad, want_step.pad);
			end
		end
	end

	task automatic test_empty_store();
		send_cmd(rpss_pkg::FUNC_EDGE, 6'd0, 1'b0);
		send_cmd(rpss_pkg::FUNC_NOTE, 6'd63, 1'b1);
		send_cmd(rpss_pkg::FUNC_TIE, 6'd0, 1'b0);
		send_cmd(rpss_pkg::FUNC_REST, 6'd63, 1'b1);
		send_cmd(rpss_pkg::FUNC_PLAY, 6'd0, 1'b1);
		send_cmd(rpss_pkg::FUNC_PLAY, 6'd63, 1'b0);
		send_cmd(rpss_pkg::FUNC_REWIND, 6'd0, 1'b0);
		send_cmd(rpss_pkg::FUNC_CLEAR, 6'd0, 1'b0);
	endtask

	task automatic test_record_play();
		send_cmd(rpss_pkg::FUNC_RECORD, 6'd0, 1'b1);
		send_cmd(rpss_pkg::FUNC_NOTE, 6'd63, 1'b0);
		send_cmd(rpss_pkg::FUNC_REST, 6'd63, 1'b0);
		send_cmd(rpss_pkg::FUNC_TIE, 6'd0, 1'b0);
		send_cmd(rpss_pkg::FUNC_TIE, 6'd63, 1'b1);
		send_cmd(rpss_pkg::FUNC_EDGE, 6'd0, 1'b0);
		send_cmd(rpss_pkg::FUNC_NOTE, 6'd0, 1'b0);
		send_cmd(rpss_pkg::FUNC_RECORD, 6'd0, 1'b0);
		send_cmd(rpss_pkg::FUNC_NOTE, 6'd21, 1'b1);
		send_cmd(rpss_pkg::FUNC_PLAY, 6'd0, 1'b1);
		repeat (5) send_cmd(rpss_pkg::FUNC_EDGE, 6'd0, 1'b0);
		send_cmd(rpss_pkg::FUNC_REWIND, 6'd0, 1'b0);
		send_cmd(rpss_pkg::FUNC_EDGE, 6'd0, 1'b0);
		send_cmd(rpss_pkg::FUNC_CLEAR, 6'd0, 1'b0);
		send_cmd(rpss_pkg::FUNC_EDGE, 6'd0, 1'b0);
	endtask

	task automatic test_full_store();
		send_cmd(rpss_pkg::FUNC_RECORD, 6'd0, 1'b1);
		repeat (rpss_pkg::MAX_STEPS) send_random_record();
		send_cmd(rpss_pkg::FUNC_TIE, 6'd33, 1'b1);
		send_cmd(rpss_pkg::FUNC_RECORD, 6'd0, 1'b1);
		repeat (rpss_pkg::MAX_STEPS + 1)
			send_cmd(rpss_pkg::FUNC_EDGE, 6'($urandom_range(0, 63)), 1'b0);
		send_cmd(rpss_pkg::FUNC_CLEAR, 6'd0, 1'b0);
		send_cmd(rpss_pkg::FUNC_RECORD, 6'd0, 1'b1);
		send_cmd(rpss_pkg::FUNC_NOTE, 6'd42, 1'b0);
		send_cmd(rpss_pkg::FUNC_EDGE, 6'd0, 1'b0);
		send_cmd(rpss_pkg::FUNC_CLEAR, 6'd0, 1'b1);
	endtask

	task automatic test_random_sequences(int target);
		int n;
		while (items_sent < target) begin
			steady = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 14) == 0)
				drain_results();
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 8))
					send_cmd(rpss_pkg::func_t'($urandom_range(0, 7)),
						6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
			end else begin
				if ($urandom_range(0, 2) != 0)
					send_cmd(rpss_pkg::FUNC_CLEAR, 6'($urandom_range(0, 63)),
						1'($urandom_range(0, 1)));
				send_cmd(rpss_pkg::FUNC_RECORD, 6'($urandom_range(0, 63)),
					$urandom_range(0, 9) != 0);
				n = ($urandom_range(0, 24) == 0) ? int'($urandom_range(90, 110))
					: int'($urandom_range(1, 12));
				repeat (n) begin
					if ($urandom_range(0, 7) == 0)
						send_cmd(rpss_pkg::FUNC_EDGE, 6'($urandom_range(0, 63)),
							1'($urandom_range(0, 1)));
					else
						send_random_record();
				end
				if ($urandom_range(0, 1) == 0)
					send_cmd(rpss_pkg::FUNC_RECORD, 6'($urandom_range(0, 63)), 1'b0);
				send_cmd(rpss_pkg::FUNC_PLAY, 6'($urandom_range(0, 63)),
					1'($urandom_range(0, 1)));
				repeat ($urandom_range(1, 30)) begin
					if ($urandom_range(0, 11) == 0)
						send_cmd(rpss_pkg::FUNC_REWIND, 6'($urandom_range(0, 63)),
							1'($urandom_range(0, 1)));
					else
						send_cmd(rpss_pkg::FUNC_EDGE, 6'($urandom_range(0, 63)),
							1'($urandom_range(0, 1)));
				end
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = rpss_pkg::FUNC_EDGE;
		steady = 1'b0;
		pattern_slots = '{default: '0};
		pattern_len = 0;
		play_pos = 0;
		last_slot = -1;
		rec_on = 1'b0;
		play_on = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		test_empty_store();
		test_record_play();
		drain_results();
		test_full_store();
		test_random_sequences(ITEM_TARGET);

		drain_results();
		$display("%0d commands sent, %0d results checked, %0d changed state or played",
			items_sent, results_seen, effective_items);
		$display("played %0d notes, %0d ties, %0d rests; wrapped %0d times, filled %0d times",
			notes_played, ties_played, rests_played, wraps_seen, store_full_hits);
		$display("%0d mismatches", errors);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
